// ===== sv/snks_pkg.sv =====
// Shared types and constants for the sorted node key search block.
`timescale 1ns / 1ps

package snks_pkg;

    // Width of the reported key position and its "none" code
    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_NONE = '1;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FLOOR = 2'd1,
        KIND_EXACT = 2'd2
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== sv/sorted_node_key_search.sv =====
// Key store of one tree node with a sequential floor and exact search.
// Load beat: written at the next free slot (slot 0 with s_restart, dropped when full); ready stays high.
// Query beat: keys are read one per cycle from the key memory into one comparator, and the
//   registered result is then offered as the result beat (an empty node skips the scan).
// Not ready from query acceptance until the result beat is taken.
// Reset (aresetn low, synchronous) empties the node; key memory contents are not cleared.
`timescale 1ns / 1ps

module sorted_node_key_search
    import snks_pkg::*;
#(
    parameter int MAX_KEYS = 32,
    parameter int KEY_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic signed [KEY_BITS-1:0] s_key_value,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_W-1:0]    m_position
);

    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEYS);

    // Key memory
    logic [KEY_BITS-1:0] key_mem [MAX_KEYS];
    logic [KEY_BITS-1:0] rd_data_reg;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;

    // Control and datapath registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                is_exact_reg, is_exact_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                issue_reg, issue_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                lt0_reg, lt0_next;
    logic                prev_le_reg, prev_le_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    found_idx_reg, found_idx_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic                in_beat;
    logic                is_query;
    logic [CNT_W-1:0]    count_dec;
    logic [IDX_W-1:0]    last_idx;
    logic                key_lt;
    logic                key_eq;
    logic                scan_last;
    logic                lt0_now;
    logic                found_now;
    logic [IDX_W-1:0]    found_idx_now;
    logic [IDX_W+POS_W-1:0] idx_ext;
    logic [IDX_W+POS_W-1:0] last_ext;

    assign in_beat   = s_valid && s_ready;
    assign is_query  = (s_kind == KIND_FLOOR) || (s_kind == KIND_EXACT);
    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];

    // Shared comparator: search key against the key read back
    assign key_lt    = $signed(key_reg) < $signed(rd_data_reg);
    assign key_eq    = key_reg == rd_data_reg;
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == last_idx);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && is_query) begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: s_ready = 1'b0;
            ST_DONE: m_valid = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    assign m_position = pos_reg;

    // Load path and scan datapath
    always_comb begin
        count_next     = count_reg;
        is_exact_next  = is_exact_reg;
        key_next       = key_reg;
        rd_idx_next    = rd_idx_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = rd_idx_reg;
        lt0_next       = lt0_reg;
        prev_le_next   = prev_le_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        pos_next       = pos_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        lt0_now        = lt0_reg;
        found_now      = found_reg;
        found_idx_now  = found_idx_reg;
        idx_ext        = '0;
        last_ext       = '0;

        // Accepted beat in idle
        if (in_beat) begin
            if (s_kind == KIND_LOAD) begin
                if (s_restart) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = CNT_W'(1);
                end else if (count_reg < CNT_MAX) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end else if (is_query) begin
                is_exact_next = s_kind == KIND_EXACT;
                key_next      = s_key_value;
                rd_idx_next   = '0;
                issue_next    = count_reg != '0;
                found_next    = 1'b0;
                prev_le_next  = 1'b0;
                lt0_next      = 1'b0;
                pos_next      = POS_NONE;
            end
        end

        // Read issue: one address per cycle up to the last stored key
        if (state_reg == ST_SCAN && issue_reg) begin
            cmp_vld_next = 1'b1;
            if (rd_idx_reg == last_idx) begin
                issue_next = 1'b0;
            end else begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end

        // Compare step on the key read back
        if (state_reg == ST_SCAN && cmp_vld_reg) begin
            if (is_exact_reg) begin
                if (key_eq && !found_reg) begin
                    found_now     = 1'b1;
                    found_idx_now = cmp_idx_reg;
                end
            end else begin
                if (cmp_idx_reg == '0) begin
                    lt0_now = key_lt;
                end else if (prev_le_reg && key_lt && !found_reg) begin
                    found_now     = 1'b1;
                    found_idx_now = cmp_idx_reg - IDX_W'(1);
                end
                prev_le_next = !key_lt;
            end
            lt0_next       = lt0_now;
            found_next     = found_now;
            found_idx_next = found_idx_now;

            // Final key: form the result
            if (scan_last) begin
                idx_ext  = {{POS_W{1'b0}}, found_idx_now};
                last_ext = {{POS_W{1'b0}}, last_idx};
                if (is_exact_reg) begin
                    pos_next = found_now ? idx_ext[POS_W-1:0] : POS_NONE;
                end else if (lt0_now) begin
                    pos_next = POS_NONE;
                end else if (!key_lt) begin
                    pos_next = last_ext[POS_W-1:0];
                end else if (found_now) begin
                    pos_next = idx_ext[POS_W-1:0];
                end else begin
                    pos_next = POS_NONE;
                end
            end
        end
    end

    // Key memory: one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= s_key_value;
        end
        rd_data_reg <= key_mem[rd_idx_reg];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        is_exact_reg  <= is_exact_next;
        key_reg       <= key_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        lt0_reg       <= lt0_next;
        prev_le_reg   <= prev_le_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        pos_reg       <= pos_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("key count above capacity");

    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && is_query) |=> !s_ready)
        else $error("ready after query beat");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_cmp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (cmp_idx_reg <= last_idx && state_reg == ST_SCAN))
        else $error("compare index beyond stored keys");

endmodule

// ===== tb/sv/sorted_node_key_search_tb.sv =====
// Self-checking testbench for the sorted node key search block.
`timescale 1ns / 1ps

module sorted_node_key_search_tb;
    import snks_pkg::*;

    localparam int MAX_KEYS = 32;
    localparam int KEY_BITS = 32;
    localparam int RANDOM_ITEMS = 550;
    // Idle margin after the last result before the leftover check
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint KEY_MIN = -64'sd2147483648;
    localparam longint KEY_MAX = 64'sd2147483647;

    // Node model: key list, floor and exact search, queue of expected positions
    class node_search_scoreboard;
        logic signed [KEY_BITS-1:0] node_keys[MAX_KEYS];
        int key_total;
        logic [POS_W-1:0] pending_pos[$];
        int mismatches;
        int checked;
        int loads;
        int floors;
        int exacts;
        int ignored;

        function new();
            key_total = 0;
            mismatches = 0;
            checked = 0;
            loads = 0;
            floors = 0;
            exacts = 0;
            ignored = 0;
        endfunction

        function logic [POS_W-1:0] floor_pos(logic signed [KEY_BITS-1:0] k);
            int i;
            if (key_total == 0 || k < node_keys[0]) return POS_NONE;
            if (k >= node_keys[key_total-1]) return POS_W'(key_total - 1);
            // no bracketing pair (keys out of order) falls through to none
            for (i = 0; i + 1 < key_total; i++) begin
                if (node_keys[i] <= k && k < node_keys[i+1]) return POS_W'(i);
            end
            return POS_NONE;
        endfunction

        function logic [POS_W-1:0] exact_pos(logic signed [KEY_BITS-1:0] k);
            int i;
            for (i = 0; i < key_total; i++) begin
                if (node_keys[i] == k) return POS_W'(i);
            end
            return POS_NONE;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        // Called for every accepted input beat
        function void note_beat(logic [1:0] kind, logic signed [KEY_BITS-1:0] k,
                                logic restart);
            case (kind)
                KIND_LOAD: begin
                    loads++;
                    if (restart) key_total = 0;
                    // full node drops the key
                    if (key_total < MAX_KEYS) begin
                        node_keys[key_total] = k;
                        key_total++;
                    end
                end
                KIND_FLOOR: begin
                    floors++;
                    pending_pos.push_back(floor_pos(k));
                end
                KIND_EXACT: begin
                    exacts++;
                    pending_pos.push_back(exact_pos(k));
                end
                default: ignored++;
            endcase
        endfunction

        // Called for every accepted result beat
        function void check_position(logic [POS_W-1:0] got);
            logic [POS_W-1:0] want;
            if (pending_pos.size() == 0) begin
                flag($sformatf("result %0d with no query pending", $signed(got)));
                return;
            end
            want = pending_pos.pop_front();
            checked++;
            if (got !== want)
                flag($sformatf("position: expected %0d, got %0d",
                               $signed(want), $signed(got)));
        endfunction

        function void count_leftovers();
            while (pending_pos.size() != 0) begin
                flag($sformatf("query never answered, expected %0d",
                               $signed(pending_pos.pop_front())));
            end
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_kind = KIND_LOAD;
    logic signed [KEY_BITS-1:0] s_key_value = '0;
    logic                       s_restart = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [POS_W-1:0]    m_position;

    node_search_scoreboard sb = new();
    bit calm = 1'b0;
    bit sink_hold = 1'b0;
    int round_no = 0;
    int random_items = 0;
    int sink_wait = 0;

    sorted_node_key_search #(
        .MAX_KEYS(MAX_KEYS),
        .KEY_BITS(KEY_BITS)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_key_value(s_key_value),
        .s_restart(s_restart),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_position(m_position)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short idle stretches, a few long ones
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [KEY_BITS-1:0] clamp_key(longint v);
        if (v < KEY_MIN) v = KEY_MIN;
        if (v > KEY_MAX) v = KEY_MAX;
        return KEY_BITS'(v);
    endfunction

    // Search key near the stored keys most of the time
    function automatic logic signed [KEY_BITS-1:0] probe_key();
        int r;
        longint k;
        if (sb.key_total == 0) return $urandom;
        r = $urandom_range(0, 9);
        k = sb.node_keys[$urandom_range(0, sb.key_total - 1)];
        case (r)
            0, 1, 2, 3: return clamp_key(k);
            4: return clamp_key(k + 1);
            5: return clamp_key(k - 1);
            6: return clamp_key(longint'(sb.node_keys[0]) - $urandom_range(1, 100));
            7: return $urandom_range(0, 1) ? KEY_BITS'(KEY_MIN) : KEY_BITS'(KEY_MAX);
            default: return $urandom;
        endcase
    endfunction

    // Offer one input beat and wait until it is taken; valid stays high afterwards
    task automatic send_beat(input logic [1:0] kind, input logic signed [KEY_BITS-1:0] k,
                             input logic restart);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 45) ? 0 : idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_key_value <= k;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(kind, k, restart);
        if (kind != KIND_UNUSED) random_items++;
    endtask

    // Load a fresh node of n keys, ascending unless messy
    task automatic build_node(input int n, input bit messy);
        longint vals[40];
        longint span;
        int unsigned cap;
        int i;
        int j;
        int mode;
        longint tmp;
        case ($urandom_range(0, 3))
            0: cap = $urandom_range(1, 4);
            1: cap = $urandom_range(5, 1000);
            2: cap = $urandom_range(1001, 1 << 24);
            default: cap = 1 << 26;
        endcase
        mode = $urandom_range(0, 5);
        if (mode == 1) begin
            // run up to the largest key
            vals[n-1] = KEY_MAX;
            for (i = n - 2; i >= 0; i--) vals[i] = vals[i+1] - $urandom_range(1, cap);
        end else begin
            span = (KEY_MAX - KEY_MIN) - longint'(n) * cap;
            vals[0] = (mode == 0) ? KEY_MIN : KEY_MIN + longint'($urandom) % (span + 1);
            for (i = 1; i < n; i++) vals[i] = vals[i-1] + $urandom_range(1, cap);
        end
        if (messy && n >= 2) begin
            j = $urandom_range(1, n - 1);
            if ($urandom_range(0, 1)) begin
                vals[j] = vals[j-1];
            end else begin
                tmp = vals[j];
                vals[j] = vals[j-1];
                vals[j-1] = tmp;
            end
        end
        for (i = 0; i < n; i++) send_beat(KIND_LOAD, KEY_BITS'(vals[i]), i == 0);
    endtask

    // Result side: check each accepted beat, then pick the next ready value
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_valid && m_ready) sb.check_position(m_position);
            if (sink_hold) begin
                m_ready <= 1'b0;
            end else if (sink_wait > 0) begin
                m_ready <= 1'b0;
                sink_wait--;
            end else if (!calm && $urandom_range(0, 99) < 30) begin
                m_ready <= 1'b0;
                sink_wait = idle_span() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off mid-run so the input side backs up
    initial begin
        wait (round_no >= 20);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (400) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin
        int n;
        int q;
        int r;
        int guard;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // empty node, ignored kind
        send_beat(KIND_FLOOR, 0, 1'b0);
        send_beat(KIND_EXACT, KEY_BITS'(KEY_MIN), 1'b1);
        send_beat(KIND_UNUSED, 32'h5A5A_A5A5, 1'b1);
        // node spanning the whole key range
        send_beat(KIND_LOAD, KEY_BITS'(KEY_MIN), 1'b1);
        send_beat(KIND_LOAD, -5, 1'b0);
        send_beat(KIND_LOAD, 0, 1'b0);
        send_beat(KIND_LOAD, 7, 1'b0);
        send_beat(KIND_LOAD, KEY_BITS'(KEY_MAX), 1'b0);
        send_beat(KIND_FLOOR, KEY_BITS'(KEY_MIN), 1'b0);
        send_beat(KIND_FLOOR, -6, 1'b0);
        send_beat(KIND_FLOOR, -5, 1'b0);
        send_beat(KIND_FLOOR, 3, 1'b1);
        send_beat(KIND_FLOOR, KEY_BITS'(KEY_MAX), 1'b0);
        send_beat(KIND_EXACT, 7, 1'b0);
        send_beat(KIND_EXACT, 8, 1'b0);
        send_beat(KIND_EXACT, KEY_BITS'(KEY_MIN), 1'b1);
        // restart, then keys out of order and a duplicate
        send_beat(KIND_LOAD, 10, 1'b1);
        send_beat(KIND_LOAD, 5, 1'b0);
        send_beat(KIND_FLOOR, 7, 1'b0);
        send_beat(KIND_FLOOR, 3, 1'b0);
        send_beat(KIND_LOAD, 5, 1'b0);
        send_beat(KIND_EXACT, 5, 1'b0);
        send_beat(KIND_FLOOR, 5, 1'b0);

        // random nodes, each followed by a burst of beats, mostly queries
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            round_no++;
            calm <= (round_no >= 10 && round_no < 15);
            r = $urandom_range(0, 9);
            if (round_no == 1) n = 34;
            else if (r < 7) n = $urandom_range(1, 8);
            else if (r < 9) n = $urandom_range(9, 31);
            else n = $urandom_range(32, 34);
            build_node(n, $urandom_range(0, 9) == 0);
            q = $urandom_range(2, 10);
            repeat (q) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_beat(KIND_UNUSED, $urandom, 1'($urandom_range(0, 1)));
                else if (r == 1)
                    send_beat(KIND_LOAD, probe_key(), 1'b0);
                else
                    send_beat(r[0] ? KIND_FLOOR : KIND_EXACT, probe_key(),
                              1'($urandom_range(0, 1)));
            end
        end
        s_valid <= 1'b0;

        // drain
        guard = 0;
        while (sb.pending_pos.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.count_leftovers();

        $display("Covered %0d loads, %0d floor and %0d exact queries, %0d unused-kind beats",
                 sb.loads, sb.floors, sb.exacts, sb.ignored);
        $display("Compared %0d positions over %0d random nodes, %0d bad",
                 sb.checked, round_no, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
